### design/hpq_pkg.sv
// Shared types, constants and helpers of the binary max-heap queue.
// Used by the level cells and the top level; depends on nothing else.
`default_nettype none

package hpq_pkg;

  localparam int CAPACITY    = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int LEVELS      = $clog2(CAPACITY + 1);
  localparam int OFF_W       = LEVELS - 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = CNT_W + 1;
  localparam int LVL_W       = $clog2(LEVELS + 1);
  localparam int KEY_FIELD_W = 32;
  localparam int OUT_CNT_W   = 7;
  localparam int STATUS_W    = 2;
  localparam int OUT_DATA_W  = 2 * KEY_FIELD_W + OUT_CNT_W + 1;

  typedef logic [KEY_WIDTH-1:0] key_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  // one request travelling along the chain: an offset within a level and a key
  typedef struct packed {
    logic             vld;
    logic [OFF_W-1:0] off;
    key_t             val;
  } hpq_msg_t;

  // words per half (even or odd offsets) of one level's store
  function automatic int level_depth(int k);
    int n;
    int rest;
    int d;
    n    = 1 << k;
    rest = CAPACITY + 1 - (1 << k);
    if (rest < n) n = rest;
    d = (n + 1) / 2;
    if (d < 1) d = 1;
    return d;
  endfunction

  // tree level of a heap index, given index plus one
  function automatic logic [LVL_W-1:0] level_of(logic [CNT_W-1:0] pos1);
    logic [LVL_W-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (pos1[i]) lvl = LVL_W'(i);
    end
    return lvl;
  endfunction

  // strict a < b, unsigned or two's complement
  function automatic logic key_less(key_t a, key_t b, logic sgn);
    key_t flip;
    flip = '0;
    flip[KEY_WIDTH-1] = sgn;
    return (a ^ flip) < (b ^ flip);
  endfunction

endpackage

`default_nettype wire

### design/hpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds one half of one heap level.
`default_nettype none

module hpq_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### design/hpq_level.sv
// One heap level cell: reads its sibling-pair store, compares and hands the
// moving key to the level above or below. Depends on hpq_pkg.
`default_nettype none

module hpq_level import hpq_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmp_signed_i,
  input  wire logic [IDX_W-1:0] base_i,
  input  wire logic [CNT_W-1:0] lim_i,
  input  wire hpq_msg_t         dn_i,
  input  wire hpq_msg_t         up_i,
  input  wire hpq_msg_t         fetch_i,
  input  wire hpq_msg_t         wr_hi_i,
  input  wire hpq_msg_t         wr_lo_i,
  output hpq_msg_t              dn_o,
  output hpq_msg_t              up_o,
  output hpq_msg_t              wr_up_o,
  output hpq_msg_t              wr_dn_o,
  output hpq_msg_t              fetch_o,
  output logic                  done_o,
  output logic      [OFF_W-1:0] raddr_o,
  output logic      [OFF_W-1:0] waddr_o,
  output key_t                  wdata_o,
  output logic                  we_even_o,
  output logic                  we_odd_o,
  input  wire key_t             rd_even_i,
  input  wire key_t             rd_odd_i
);

  logic             pend_dn_q, pend_up_q, pend_fe_q;
  logic [OFF_W-1:0] off_q;
  key_t             val_q;

  logic [IDX_W-1:0] left_idx, child_idx, grand_idx;
  logic             right_ok, sel;
  key_t             child, parent;
  logic [OFF_W-1:0] coff, poff;
  hpq_msg_t         self_wr, wr_all;

  // request address: children pair, parent word, or a plain fetch
  always_comb begin
    if (dn_i.vld) begin
      raddr_o = dn_i.off;
    end else if (up_i.vld) begin
      raddr_o = up_i.off >> 2;
    end else begin
      raddr_o = fetch_i.off >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_dn_q <= 1'b0;
      pend_up_q <= 1'b0;
      pend_fe_q <= 1'b0;
    end else begin
      pend_dn_q <= dn_i.vld;
      pend_up_q <= up_i.vld;
      pend_fe_q <= fetch_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dn_i.vld) begin
      off_q <= dn_i.off;
      val_q <= dn_i.val;
    end else if (up_i.vld) begin
      off_q <= up_i.off;
      val_q <= up_i.val;
    end else begin
      off_q <= fetch_i.off;
      val_q <= fetch_i.val;
    end
  end

  assign left_idx  = base_i + IDX_W'({off_q, 1'b0});
  assign right_ok  = (left_idx + IDX_W'(1)) < IDX_W'(lim_i);
  assign sel       = right_ok && !key_less(rd_odd_i, rd_even_i, cmp_signed_i);
  assign child     = sel ? rd_odd_i : rd_even_i;
  assign coff      = OFF_W'({off_q, sel});
  assign child_idx = left_idx + IDX_W'(sel);
  assign grand_idx = {child_idx[IDX_W-2:0], 1'b1};
  assign poff      = off_q >> 1;
  assign parent    = poff[0] ? rd_odd_i : rd_even_i;

  always_comb begin
    dn_o    = '0;
    up_o    = '0;
    wr_up_o = '0;
    wr_dn_o = '0;
    fetch_o = '0;
    self_wr = '0;
    done_o  = 1'b0;
    if (pend_dn_q) begin
      if (key_less(val_q, child, cmp_signed_i)) begin
        wr_up_o = '{vld: 1'b1, off: off_q, val: child};
        if (grand_idx < IDX_W'(lim_i)) begin
          dn_o = '{vld: 1'b1, off: coff, val: val_q};
        end else begin
          // no grandchildren: settle the key in the vacated child slot
          self_wr = '{vld: 1'b1, off: coff, val: val_q};
          done_o  = 1'b1;
        end
      end else begin
        wr_up_o = '{vld: 1'b1, off: off_q, val: val_q};
        done_o  = 1'b1;
      end
    end
    if (pend_up_q) begin
      if (key_less(parent, val_q, cmp_signed_i)) begin
        wr_dn_o = '{vld: 1'b1, off: off_q, val: parent};
        up_o    = '{vld: 1'b1, off: poff, val: val_q};
      end else begin
        wr_dn_o = '{vld: 1'b1, off: off_q, val: val_q};
        done_o  = 1'b1;
      end
    end
    if (pend_fe_q) begin
      fetch_o = '{vld: 1'b1, off: off_q, val: off_q[0] ? rd_odd_i : rd_even_i};
    end
  end

  // at most one writer is active in any cycle
  assign wr_all    = hpq_msg_t'(wr_hi_i | wr_lo_i | self_wr);
  assign waddr_o   = wr_all.off >> 1;
  assign wdata_o   = wr_all.val;
  assign we_even_o = wr_all.vld & ~wr_all.off[0];
  assign we_odd_o  = wr_all.vld & wr_all.off[0];

endmodule

`default_nettype wire

### design/binary_max_heap_queue.sv
// Top level of the binary max-heap queue: root register, sequencer, output
// register and the chain of level cells. Depends on hpq_pkg, hpq_level, hpq_ram.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: cmd; tdata: key
//  m_axis    out  m_axis_tvalid/tready       tuser: status; tdata: see port
//  cfg       in   cfg_valid_i/cfg_ready_o    cfg_data_i: compare_signed
//
// One request at a time. A push into a non-empty queue with room reads the
// parent of the free slot and takes one compare per further level (the root
// compares together with level one). A pop that leaves entries fetches the last
// one and, if two or more remain, reads at level one and takes one compare per
// level it sinks, paced by the registered read of each level store. Every
// request ends by loading the output register. Reset empties the queue at once;
// store contents need no clearing. A stalled result holds in the output
// register; the next request is still taken, then holds in S_FIN until it frees.
`default_nettype none

module binary_max_heap_queue import hpq_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [KEY_FIELD_W-1:0] s_axis_tdata,  // [31:0] key
  input  wire logic [0:0]             s_axis_tuser,  // [0] cmd
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [31:0] popped_key, [63:32] max_key, [70:64] entry_count, [71] is_empty
  output logic      [OUT_DATA_W-1:0]  m_axis_tdata,
  output logic      [STATUS_W-1:0]    m_axis_tuser,  // [1:0] status
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [0:0]             cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_SIFT  = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             cmp_signed_q;
  key_t             root_q, root_d;
  status_e          status_q, status_d;
  key_t             popped_q, popped_d;
  hpq_msg_t         inj_up_q, inj_up_d;
  logic [LVL_W-1:0] inj_lvl_q, inj_lvl_d;
  hpq_msg_t         dn_inj_q, dn_inj_d;
  hpq_msg_t         fetch_q, fetch_d;
  logic [LVL_W-1:0] fetch_lvl_q, fetch_lvl_d;
  logic             m_valid_q;
  logic [STATUS_W-1:0]   m_user_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  hpq_msg_t dn_to    [LEVELS+1];
  hpq_msg_t up_out   [LEVELS+1];
  hpq_msg_t up_to    [LEVELS];
  hpq_msg_t wrup_out [LEVELS+1];
  hpq_msg_t wrdn_to  [LEVELS+1];
  hpq_msg_t fe_rsp   [LEVELS];
  logic     done_v   [LEVELS];

  hpq_msg_t         root_wr_dn, fe_any;
  logic             root_done, any_done;
  logic             accept, out_load;
  key_t             key_in, out_max;
  logic [CNT_W-1:0] pos1;
  logic [LVL_W-1:0] pos_lvl;
  logic [CNT_W-1:0] pos_off;

  assign cfg_ready_o = 1'b1;
  assign key_in      = KEY_WIDTH'(s_axis_tdata);

  // ---------------------------------------------------------------- chain
  assign dn_to[0]    = '0;
  assign dn_to[1]    = dn_inj_q;
  assign wrdn_to[0]  = '0;
  assign wrdn_to[1]  = root_wr_dn;
  assign up_out[0]   = '0;
  assign up_out[LEVELS]   = '0;
  assign wrup_out[0] = '0;
  assign wrup_out[LEVELS] = '0;
  assign fe_rsp[0]   = '0;
  assign done_v[0]   = root_done;

  for (genvar j = 0; j < LEVELS; j++) begin : g_up
    assign up_to[j] = hpq_msg_t'(up_out[j+1] |
                      ((inj_up_q.vld && inj_lvl_q == LVL_W'(j)) ? inj_up_q : hpq_msg_t'('0)));
  end

  for (genvar k = 1; k < LEVELS; k++) begin : g_lvl
    localparam int Depth = level_depth(k);
    localparam int Aw    = (Depth > 1) ? $clog2(Depth) : 1;

    logic [OFF_W-1:0] raddr, waddr;
    key_t             wdata, rd_even, rd_odd;
    logic             we_even, we_odd;
    hpq_msg_t         fe_in;

    assign fe_in = (fetch_q.vld && fetch_lvl_q == LVL_W'(k)) ? fetch_q : hpq_msg_t'('0);

    hpq_level u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmp_signed_i (cmp_signed_q),
      .base_i       (IDX_W'((1 << k) - 1)),
      .lim_i        (count_q),
      .dn_i         (dn_to[k]),
      .up_i         (up_to[k]),
      .fetch_i      (fe_in),
      .wr_hi_i      (wrdn_to[k]),
      .wr_lo_i      (wrup_out[k+1]),
      .dn_o         (dn_to[k+1]),
      .up_o         (up_out[k]),
      .wr_up_o      (wrup_out[k]),
      .wr_dn_o      (wrdn_to[k+1]),
      .fetch_o      (fe_rsp[k]),
      .done_o       (done_v[k]),
      .raddr_o      (raddr),
      .waddr_o      (waddr),
      .wdata_o      (wdata),
      .we_even_o    (we_even),
      .we_odd_o     (we_odd),
      .rd_even_i    (rd_even),
      .rd_odd_i     (rd_odd)
    );

    hpq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(Depth)) u_even (
      .clk_i   (clk_i),
      .we_i    (we_even),
      .waddr_i (waddr[Aw-1:0]),
      .wdata_i (wdata),
      .raddr_i (raddr[Aw-1:0]),
      .rdata_o (rd_even)
    );

    hpq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(Depth)) u_odd (
      .clk_i   (clk_i),
      .we_i    (we_odd),
      .waddr_i (waddr[Aw-1:0]),
      .wdata_i (wdata),
      .raddr_i (raddr[Aw-1:0]),
      .rdata_o (rd_odd)
    );
  end

  always_comb begin
    fe_any   = '0;
    any_done = 1'b0;
    for (int j = 0; j < LEVELS; j++) begin
      fe_any   = hpq_msg_t'(fe_any | fe_rsp[j]);
      any_done = any_done | done_v[j];
    end
  end

  // ------------------------------------------------------------ sequencer
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == S_FIN) && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_max  = (count_q != '0) ? root_q : '0;

  // position of the free slot on a push, or of the last entry on a pop
  assign pos1    = (s_axis_tuser[0] == CMD_PUSH) ? count_q + CNT_W'(1) : count_q;
  assign pos_lvl = level_of(pos1);
  assign pos_off = pos1 & ~(CNT_W'(1) << pos_lvl);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    root_d      = root_q;
    status_d    = status_q;
    popped_d    = popped_q;
    inj_up_d    = '0;
    inj_lvl_d   = inj_lvl_q;
    dn_inj_d    = '0;
    fetch_d     = '0;
    fetch_lvl_d = fetch_lvl_q;
    root_wr_dn  = '0;
    root_done   = 1'b0;

    // root register as the top cell of the chain
    if (up_to[0].vld) begin
      if (key_less(root_q, up_to[0].val, cmp_signed_q)) begin
        root_wr_dn = '{vld: 1'b1, off: up_to[0].off, val: root_q};
        root_d     = up_to[0].val;
      end else begin
        root_wr_dn = '{vld: 1'b1, off: up_to[0].off, val: up_to[0].val};
      end
      root_done = 1'b1;
    end
    if (wrup_out[1].vld) root_d = wrup_out[1].val;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_DONE;
          popped_d = '0;
          state_d  = S_FIN;
          if (s_axis_tuser[0] == CMD_PUSH) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
            end else if (count_q == '0) begin
              root_d  = key_in;
              count_d = CNT_W'(1);
            end else begin
              inj_up_d  = '{vld: 1'b1, off: OFF_W'(pos_off), val: key_in};
              inj_lvl_d = pos_lvl - LVL_W'(1);
              count_d   = count_q + CNT_W'(1);
              state_d   = S_SIFT;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              popped_d = root_q;
              count_d  = count_q - CNT_W'(1);
              if (count_q != CNT_W'(1)) begin
                fetch_d     = '{vld: 1'b1, off: OFF_W'(pos_off), val: '0};
                fetch_lvl_d = pos_lvl;
                state_d     = S_FETCH;
              end
            end
          end
        end
      end
      S_FETCH: begin
        if (fe_any.vld) begin
          if (count_q >= CNT_W'(2)) begin
            dn_inj_d = '{vld: 1'b1, off: '0, val: fe_any.val};
            state_d  = S_SIFT;
          end else begin
            root_d  = fe_any.val;
            state_d = S_FIN;
          end
        end
      end
      S_SIFT: begin
        if (any_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      cmp_signed_q <= 1'b0;
      inj_up_q     <= '0;
      inj_lvl_q    <= '0;
      dn_inj_q     <= '0;
      fetch_q      <= '0;
      fetch_lvl_q  <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      inj_up_q    <= inj_up_d;
      inj_lvl_q   <= inj_lvl_d;
      dn_inj_q    <= dn_inj_d;
      fetch_q     <= fetch_d;
      fetch_lvl_q <= fetch_lvl_d;
      if (cfg_valid_i && cfg_ready_o) cmp_signed_q <= cfg_data_i[0];
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    root_q   <= root_d;
    status_q <= status_d;
    popped_q <= popped_d;
    if (out_load) begin
      m_user_q <= status_q;
      m_data_q <= {(count_q == '0), OUT_CNT_W'(count_q),
                   KEY_FIELD_W'(out_max), KEY_FIELD_W'(popped_q)};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

  // ----------------------------------------------------------- assertions
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_done_in_sift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_done |-> state_q == S_SIFT)
    else $error("sift finished outside a sift");

  a_fetch_in_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_any.vld |-> state_q == S_FETCH)
    else $error("fetch data outside a fetch");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_user_q == ST_FULL) |->
      m_data_q[2*KEY_FIELD_W +: OUT_CNT_W] == OUT_CNT_W'(CAPACITY))
    else $error("full status with room left");

endmodule

`default_nettype wire

### tb/binary_max_heap_queue_test.sv
// Self-checking testbench for the binary max-heap queue: pushes and pops keys
// under both key orderings and compares every result with its own heap model.
// Depends on hpq_pkg and binary_max_heap_queue.
`default_nettype none

module binary_max_heap_queue_test import hpq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SEGMENTS = 12;
  localparam int SEGMENT_ITEMS = 152;

  typedef struct {
    status_e              status;
    key_t                 popped_key;
    key_t                 max_key;
    logic [OUT_CNT_W-1:0] entry_count;
    logic                 is_empty;
  } heap_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [KEY_FIELD_W-1:0] s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [0:0]            cfg_data_i = '0;

  // heap model and the results it still owes
  key_t                  heap_keys [CAPACITY];
  int unsigned           held_keys;
  bit                    signed_order;
  heap_result_t          pending_results[$];

  int unsigned           tx_idle_pct;
  int unsigned           rx_idle_pct;
  int unsigned           mismatches;
  int unsigned           results_checked;
  int unsigned           push_count;
  int unsigned           pop_count;
  int unsigned           full_rejects;
  int unsigned           empty_pops;
  int unsigned           stall_cycles;

  binary_max_heap_queue u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit key_below(key_t a, key_t b);
    if (signed_order) begin
      return $signed(a) < $signed(b);
    end
    return a < b;
  endfunction

  function automatic void swap_keys(int unsigned i, int unsigned j);
    key_t t;
    t = heap_keys[i];
    heap_keys[i] = heap_keys[j];
    heap_keys[j] = t;
  endfunction

  function automatic heap_result_t apply_request(cmd_e cmd, key_t key);
    heap_result_t res;
    int unsigned  pos;
    int unsigned  parent;
    int unsigned  left;
    int unsigned  pick;
    int unsigned  last;
    res.status = ST_DONE;
    res.popped_key = '0;
    if (cmd == CMD_PUSH) begin
      push_count++;
      if (held_keys >= CAPACITY) begin
        res.status = ST_FULL;
        full_rejects++;
      end else begin
        pos = held_keys;
        heap_keys[pos] = key;
        // climb while the parent is strictly smaller
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!key_below(heap_keys[parent], heap_keys[pos])) break;
          swap_keys(parent, pos);
          pos = parent;
        end
        held_keys++;
      end
    end else begin
      pop_count++;
      if (held_keys == 0) begin
        res.status = ST_EMPTY;
        empty_pops++;
      end else begin
        last = held_keys - 1;
        swap_keys(0, last);
        pos = 0;
        // sink: right child wins ties with the left one
        forever begin
          left = 2 * pos + 1;
          if (left >= last) break;
          pick = left;
          if (left + 1 < last && !key_below(heap_keys[left + 1], heap_keys[left])) begin
            pick = left + 1;
          end
          if (!key_below(heap_keys[pos], heap_keys[pick])) break;
          swap_keys(pick, pos);
          pos = pick;
        end
        res.popped_key = heap_keys[last];
        held_keys = last;
      end
    end
    res.max_key = (held_keys > 0) ? heap_keys[0] : '0;
    res.entry_count = OUT_CNT_W'(held_keys);
    res.is_empty = (held_keys == 0);
    return res;
  endfunction

  // result side: random back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    heap_result_t exp_res;
    key_t         got_popped;
    key_t         got_max;
    logic [OUT_CNT_W-1:0] got_count;
    logic         got_empty;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_popped = m_axis_tdata[31:0];
      got_max = m_axis_tdata[63:32];
      got_count = m_axis_tdata[70:64];
      got_empty = m_axis_tdata[71];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d popped %h max %h count %0d empty %b",
                   m_axis_tuser, got_popped, got_max, got_count, got_empty);
        end
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        if (m_axis_tuser !== exp_res.status || got_popped !== exp_res.popped_key ||
            got_max !== exp_res.max_key || got_count !== exp_res.entry_count ||
            got_empty !== exp_res.is_empty) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected status %0d popped %h max %h count %0d empty %b",
                     results_checked, exp_res.status, exp_res.popped_key, exp_res.max_key,
                     exp_res.entry_count, exp_res.is_empty);
            $display("result %0d: got      status %0d popped %h max %h count %0d empty %b",
                     results_checked, m_axis_tuser, got_popped, got_max, got_count,
                     got_empty);
          end
        end
      end
    end
  end

  // watchdog: a handshake on any channel counts as progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // entered and left at a falling edge; valid stays high for a back-to-back request
  task automatic send_request(cmd_e cmd, key_t key);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= key;
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_request(cmd, key));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_compare_order(bit sgn);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= sgn;
    do @(posedge clk_i); while (!cfg_ready_o);
    signed_order = sgn;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic key_t pick_key();
    case ($urandom_range(3))
      0: return $urandom;
      1: return key_t'($urandom_range(7));
      2: begin
        case ($urandom_range(3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return 32'h8000_0000 ^ key_t'($urandom_range(3)) ^
                      {1'($urandom_range(1)), 31'd0};
    endcase
  endfunction

  task automatic test_unsigned_extremes();
    set_compare_order(1'b0);
    send_request(CMD_POP, 32'hFFFF_FFFF);
    send_request(CMD_PUSH, 32'h0000_0000);
    send_request(CMD_PUSH, 32'hFFFF_FFFF);
    send_request(CMD_PUSH, 32'h8000_0000);
    send_request(CMD_PUSH, 32'h7FFF_FFFF);
    send_request(CMD_PUSH, 32'h0000_0001);
    send_request(CMD_PUSH, 32'h7FFF_FFFF);
    repeat (7) send_request(CMD_POP, 32'h0000_0000);
  endtask

  task automatic test_signed_order();
    set_compare_order(1'b1);
    send_request(CMD_PUSH, 32'h8000_0000);
    send_request(CMD_PUSH, 32'hFFFF_FFFF);
    send_request(CMD_PUSH, 32'h0000_0000);
    send_request(CMD_PUSH, 32'h7FFF_FFFF);
    send_request(CMD_PUSH, 32'h8000_0000);
    repeat (5) send_request(CMD_POP, 32'h5555_AAAA);
  endtask

  // alternate filling and draining runs so full and empty are both hit often
  task automatic test_fill_and_drain();
    int unsigned push_pct;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == SEGMENTS / 3) begin
        tx_idle_pct = 85;
        rx_idle_pct = 36;
      end else if (seg == 2 * SEGMENTS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_compare_order(seg[0] ^ seg[2]);
      push_pct = seg[0] ? 25 : 78;
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if ($urandom_range(99) < push_pct) begin
          send_request(CMD_PUSH, pick_key());
        end else begin
          send_request(CMD_POP, $urandom);
        end
      end
    end
  endtask

  initial begin
    held_keys = 0;
    signed_order = 1'b0;
    tx_idle_pct = 36;
    rx_idle_pct = 85;
    mismatches = 0;
    results_checked = 0;
    push_count = 0;
    pop_count = 0;
    full_rejects = 0;
    empty_pops = 0;
    stall_cycles = 0;
    foreach (heap_keys[i]) heap_keys[i] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_unsigned_extremes();
    test_signed_order();
    test_fill_and_drain();

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("covered %0d pushes (%0d refused when full) and %0d pops (%0d on empty)",
             push_count, full_rejects, pop_count, empty_pops);
    $display("in both key orderings; %0d results checked, %0d mismatches",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
